### src/voss_pink_noise_note_generator_assert.svh
// Assertion macros shared by the pink-noise note generator RTL.
`ifndef VOSS_PINK_NOISE_NOTE_GENERATOR_ASSERT_SVH
`define VOSS_PINK_NOISE_NOTE_GENERATOR_ASSERT_SVH

// Same-cycle implication.
`define VPN_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define VPN_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/vpn_pkg.sv
// Shared types and constants of the pink-noise note generator.
`default_nettype none

package vpn_pkg;

   localparam int DELAY_W     = 16;
   localparam int NOTE_W      = 7;
   localparam int POS_W       = 8;
   localparam int DICE_W      = 4;
   localparam int SEED_W      = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int SUM_W       = 10;
   localparam int NOTE_SUM_W  = SUM_W + 1;
   localparam int LEN_W       = POS_W + 1;
   localparam int SEL_W       = $clog2(POS_W);
   localparam int DIV_W       = 16;
   localparam int DIV_CNT_W   = $clog2(DIV_W);
   localparam int DIVISOR_W   = NOTE_W;

   localparam logic [SEED_W-1:0]  LFSR_TAPS   = 32'h8020_0003;
   localparam logic [DELAY_W-1:0] COUNT_RESET = 16'd10;
   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd10;
   localparam logic [NOTE_W-1:0]  MIN_RESET   = 7'd36;
   localparam logic [NOTE_W-1:0]  MAX_RESET   = 7'd98;
   localparam logic [DICE_W-1:0]  DICE_RESET  = 4'd4;
   localparam logic [SEED_W-1:0]  SEED_RESET  = 32'd1;
   localparam logic [NOTE_W-1:0]  NOTE_MAX    = 7'd127;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DELAY_FACTOR = 3'd0,
      CSR_MIN_NOTE     = 3'd1,
      CSR_MAX_NOTE     = 3'd2,
      CSR_DICE_COUNT   = 3'd3,
      CSR_LFSR_SEED    = 3'd4
   } vpn_csr_idx_type;

   typedef struct packed {
      logic accept;
      logic span_start;
      logic load_span;
      logic die_skip;
      logic reroll_start;
      logic die_store;
      logic out_load;
   } vpn_cmd_type;

   typedef struct packed {
      logic fire;
      logic div_done;
      logic die_end;
      logic die_changed;
      logic out_free;
   } vpn_status_type;

endpackage

`default_nettype wire

### src/vpn_if.sv
// Channel interfaces: tick input, note output and register write port.
`default_nettype none

interface vpn_req_if import vpn_pkg::*; ();
   logic valid;
   logic ready;
   logic tick;
   modport source (output valid, output tick, input ready);
   modport sink (input valid, input tick, output ready);
endinterface

interface vpn_rsp_if import vpn_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [NOTE_W-1:0] note;
   logic [POS_W-1:0]  sequence_position;
   modport source (output valid, output note, output sequence_position, input ready);
   modport sink (input valid, input note, input sequence_position, output ready);
endinterface

interface vpn_csr_if import vpn_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### src/voss_pink_noise_note_generator.sv
// Non-firing tick beats are taken while idle and give no result beat.
// A firing beat gives its note once the span and every rerolled die are worked out;
// the 16-step serial divider is shared by the span and each reroll.
// One firing beat is worked on at a time.
// Reset: synchronous; registers take their reset values, dice clear, LFSR loads 1.
`default_nettype none

module voss_pink_noise_note_generator import vpn_pkg::*; #(
   parameter int MAX_DICE = 8
) (
   input  logic      clock,
   input  logic      reset,
   vpn_req_if.sink   req_ch,
   vpn_rsp_if.source rsp_ch,
   vpn_csr_if.sink   csr_ch
);

   vpn_cmd_type    cmd;
   vpn_status_type status;
   logic           req_ready;

   assign req_ch.ready = req_ready;

   vpn_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid_i (req_ch.valid),
      .req_ready_o (req_ready),
      .status_i    (status),
      .cmd_o       (cmd)
   );

   vpn_dp #(
      .MAX_DICE (MAX_DICE)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd_i    (cmd),
      .status_o (status),
      .tick_i   (req_ch.tick),
      .rsp_ch   (rsp_ch),
      .csr_ch   (csr_ch)
   );

endmodule

`default_nettype wire

### src/vpn_div.sv
// Serial restoring divider, one quotient bit per cycle.
`default_nettype none
`include "voss_pink_noise_note_generator_assert.svh"

module vpn_div import vpn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start_i,
   input  logic [DIV_W-1:0]     dividend_i,
   input  logic [DIVISOR_W-1:0] divisor_i,
   output logic                 done_o,
   output logic [DIV_W-1:0]     quotient_o,
   output logic [DIVISOR_W-1:0] remainder_o
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_W-1:0]     quo_ff;
   logic [DIV_W-1:0]     quo_in;
   logic [DIVISOR_W-1:0] rem_ff;
   logic [DIVISOR_W-1:0] rem_in;
   logic [DIVISOR_W-1:0] dvs_ff;
   logic [DIVISOR_W:0]   trial;
   logic [DIVISOR_W:0]   trial_diff;
   logic                 ge;

   assign trial      = {rem_ff, quo_ff[DIV_W-1]};
   assign ge         = trial >= {1'b0, dvs_ff};
   assign trial_diff = trial - {1'b0, dvs_ff};
   assign rem_in     = ge ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
   assign quo_in     = {quo_ff[DIV_W-2:0], ge};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start_i) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_CNT_W'(DIV_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start_i) begin
         quo_ff <= dividend_i;
         rem_ff <= '0;
         dvs_ff <= divisor_i;
      end else if (busy_ff) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done_o      = done_ff;
   assign quotient_o  = quo_ff;
   assign remainder_o = rem_ff;

   `VPN_ASSERT_IMPL(a_rem_below_divisor, clock, reset, busy_ff, rem_ff < dvs_ff, "partial remainder not below divisor")

endmodule

`default_nettype wire

### src/vpn_dp.sv
// Datapath: registers, tick divider, sequence index, dice, LFSR and note output.
`default_nettype none
`include "voss_pink_noise_note_generator_assert.svh"

module vpn_dp import vpn_pkg::*; #(
   parameter int MAX_DICE = 8
) (
   input  logic           clock,
   input  logic           reset,
   input  vpn_cmd_type    cmd_i,
   output vpn_status_type status_o,
   input  logic           tick_i,
   vpn_rsp_if.source      rsp_ch,
   vpn_csr_if.sink        csr_ch
);

   localparam int DIE_IDX_W = (MAX_DICE > 1) ? $clog2(MAX_DICE) : 1;
   localparam int RESET_EFF = (int'(DICE_RESET) > MAX_DICE) ? MAX_DICE : int'(DICE_RESET);
   localparam logic [POS_W-1:0] PREV_RESET = POS_W'((1 << RESET_EFF) - 1);

   logic [DELAY_W-1:0]   delay_ff;
   logic [NOTE_W-1:0]    min_ff;
   logic [NOTE_W-1:0]    max_ff;
   logic [DICE_W-1:0]    dice_ff;
   logic [SEED_W-1:0]    lfsr_ff;
   logic [DELAY_W-1:0]   tick_cnt_ff;
   logic [POS_W-1:0]     seq_ff;
   logic [POS_W-1:0]     prev_ff;
   logic [NOTE_W-1:0]    die_ff [MAX_DICE];
   logic [DIVISOR_W-1:0] span_ff;
   logic [DICE_W-1:0]    die_cnt_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic                 rsp_valid_ff;
   logic [NOTE_W-1:0]    note_ff;
   logic [POS_W-1:0]     pos_ff;

   logic [DICE_W-1:0]     eff_dice;
   logic [NOTE_W-1:0]     span_diff;
   logic [SEED_W-1:0]     lfsr_next;
   logic [DIE_IDX_W-1:0]  die_sel;
   logic [SEL_W-1:0]      seq_sel;
   logic [NOTE_W-1:0]     die_rd;
   logic [NOTE_SUM_W-1:0] note_sum;
   logic [NOTE_W-1:0]     note_in;
   logic [LEN_W-1:0]      seq_len;
   logic [LEN_W-1:0]      seq_inc;
   logic [LEN_W-1:0]      len_m1;
   logic                  fire;
   logic                  out_free;

   logic                  div_start;
   logic [DIV_W-1:0]      div_dividend;
   logic [DIVISOR_W-1:0]  div_divisor;
   logic                  div_done;
   logic [DIV_W-1:0]      div_quo;
   logic [DIVISOR_W-1:0]  div_rem;

   always_comb begin
      if (dice_ff == '0) begin
         eff_dice = DICE_W'(1);
      end else if (dice_ff > DICE_W'(MAX_DICE)) begin
         eff_dice = DICE_W'(MAX_DICE);
      end else begin
         eff_dice = dice_ff;
      end
   end

   assign span_diff = (max_ff > min_ff) ? (max_ff - min_ff) : '0;
   assign lfsr_next = lfsr_ff[0] ? ((lfsr_ff >> 1) ^ LFSR_TAPS) : (lfsr_ff >> 1);
   assign die_sel   = die_cnt_ff[DIE_IDX_W-1:0];
   assign seq_sel   = die_cnt_ff[SEL_W-1:0];
   assign die_rd    = die_ff[die_sel];
   assign note_sum  = NOTE_SUM_W'(min_ff) + NOTE_SUM_W'(sum_ff);
   assign note_in   = (note_sum > NOTE_SUM_W'(NOTE_MAX)) ? NOTE_MAX : note_sum[NOTE_W-1:0];
   assign seq_len   = LEN_W'(1) << eff_dice;
   assign seq_inc   = LEN_W'(seq_ff) + LEN_W'(1);
   assign len_m1    = seq_len - LEN_W'(1);
   assign fire      = tick_i && (tick_cnt_ff >= delay_ff);
   assign out_free  = !rsp_valid_ff || rsp_ch.ready;

   assign div_start    = cmd_i.span_start || cmd_i.reroll_start;
   assign div_dividend = cmd_i.span_start ? DIV_W'(span_diff) : lfsr_next[DIV_W-1:0];
   assign div_divisor  = cmd_i.span_start ? DIVISOR_W'(eff_dice) : span_ff;

   vpn_div u_div (
      .clock       (clock),
      .reset       (reset),
      .start_i     (div_start),
      .dividend_i  (div_dividend),
      .divisor_i   (div_divisor),
      .done_o      (div_done),
      .quotient_o  (div_quo),
      .remainder_o (div_rem)
   );

   // Config registers and LFSR
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DELAY_RESET;
         min_ff   <= MIN_RESET;
         max_ff   <= MAX_RESET;
         dice_ff  <= DICE_RESET;
         lfsr_ff  <= SEED_RESET;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_DELAY_FACTOR: delay_ff <= csr_ch.data[DELAY_W-1:0];
            CSR_MIN_NOTE:     min_ff   <= csr_ch.data[NOTE_W-1:0];
            CSR_MAX_NOTE:     max_ff   <= csr_ch.data[NOTE_W-1:0];
            CSR_DICE_COUNT:   dice_ff  <= csr_ch.data[DICE_W-1:0];
            CSR_LFSR_SEED: begin
               lfsr_ff <= (csr_ch.data[SEED_W-1:0] == '0) ? SEED_RESET
                                                          : csr_ch.data[SEED_W-1:0];
            end
            default: ;
         endcase
      end else if (cmd_i.reroll_start) begin
         lfsr_ff <= lfsr_next;
      end
   end

   // Tick divider and sequence index
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_cnt_ff <= COUNT_RESET;
         seq_ff      <= '0;
         prev_ff     <= PREV_RESET;
      end else begin
         if (cmd_i.accept && tick_i) begin
            tick_cnt_ff <= fire ? '0 : (tick_cnt_ff + 1'b1);
         end
         if (cmd_i.out_load) begin
            if (seq_inc >= seq_len) begin
               seq_ff  <= '0;
               prev_ff <= len_m1[POS_W-1:0];
            end else begin
               seq_ff  <= seq_inc[POS_W-1:0];
               prev_ff <= seq_ff;
            end
         end
      end
   end

   // Dice
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_DICE; i++) begin
            die_ff[i] <= '0;
         end
      end else if (cmd_i.die_store) begin
         die_ff[die_sel] <= div_rem;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.load_span) begin
         span_ff    <= (div_quo == '0) ? DIVISOR_W'(1) : div_quo[DIVISOR_W-1:0];
         die_cnt_ff <= '0;
         sum_ff     <= '0;
      end else if (cmd_i.die_skip) begin
         die_cnt_ff <= die_cnt_ff + 1'b1;
         sum_ff     <= sum_ff + SUM_W'(die_rd);
      end else if (cmd_i.die_store) begin
         die_cnt_ff <= die_cnt_ff + 1'b1;
         sum_ff     <= sum_ff + SUM_W'(div_rem);
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd_i.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.out_load) begin
         note_ff <= note_in;
         pos_ff  <= seq_ff;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.note              = note_ff;
   assign rsp_ch.sequence_position = pos_ff;
   assign csr_ch.ready             = 1'b1;

   assign status_o.fire        = fire;
   assign status_o.div_done    = div_done;
   assign status_o.die_end     = die_cnt_ff >= eff_dice;
   assign status_o.die_changed = seq_ff[seq_sel] != prev_ff[seq_sel];
   assign status_o.out_free    = out_free;

   `VPN_ASSERT_IMPL(a_lfsr_nonzero, clock, reset, 1'b1, lfsr_ff != '0, "LFSR reached the all-zero state")
   `VPN_ASSERT_NEXT(a_out_loaded, clock, reset, cmd_i.out_load, rsp_valid_ff && pos_ff == $past(seq_ff), "note beat not presented after load")

endmodule

`default_nettype wire

### src/vpn_ctrl.sv
// Controller: sequences span division, dice rerolls and note output.
`default_nettype none
`include "voss_pink_noise_note_generator_assert.svh"

module vpn_ctrl import vpn_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid_i,
   output logic           req_ready_o,
   input  vpn_status_type status_i,
   output vpn_cmd_type    cmd_o
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SPAN,
      S_DIE,
      S_REROLL,
      S_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_ready_o = (state_ff == S_IDLE);
   assign accept      = req_valid_i && req_ready_o;

   always_comb begin
      state_in = state_ff;
      cmd_o    = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd_o.accept = accept;
            if (accept && status_i.fire) begin
               cmd_o.span_start = 1'b1;
               state_in         = S_SPAN;
            end
         end
         S_SPAN: begin
            if (status_i.div_done) begin
               cmd_o.load_span = 1'b1;
               state_in        = S_DIE;
            end
         end
         S_DIE: begin
            priority if (status_i.die_end) begin
               state_in = S_OUT;
            end else if (status_i.die_changed) begin
               cmd_o.reroll_start = 1'b1;
               state_in           = S_REROLL;
            end else begin
               cmd_o.die_skip = 1'b1;
            end
         end
         S_REROLL: begin
            if (status_i.div_done) begin
               cmd_o.die_store = 1'b1;
               state_in        = S_DIE;
            end
         end
         S_OUT: begin
            if (status_i.out_free) begin
               cmd_o.out_load = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `VPN_ASSERT_IMPL(a_load_needs_slot, clock, reset, cmd_o.out_load, status_i.out_free, "output register overwritten")

endmodule

`default_nettype wire
